// ===== rtl/core/qgi_pkg.sv =====
package qgi_pkg;

  localparam int MUL_W      = 33;
  localparam int PROD_W     = 66;
  localparam int ACC_W      = 58;
  localparam int NQ_W       = 44;
  localparam int ROOT_STEPS = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_HI_MUL,
    ST_HI_ACC,
    ST_LO_MUL,
    ST_LO_ACC,
    ST_CHECK,
    ST_SCALE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    QS_W = 2'd0,
    QS_X = 2'd1,
    QS_Y = 2'd2,
    QS_Z = 2'd3
  } qsel_t;

  typedef enum logic [1:0] {
    RS_X = 2'd0,
    RS_Y = 2'd1,
    RS_Z = 2'd2
  } rsel_t;

  typedef struct packed {
    qsel_t qsel;
    rsel_t rsel;
    logic  neg;
  } term_sel_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rd_req_t;

  // q * (0, w) cross terms, one row per quaternion component
  function automatic term_sel_t term_sel(input logic [1:0] comp, input logic [1:0] term);
    term_sel_t ts;
    ts = '{qsel: QS_W, rsel: RS_X, neg: 1'b0};
    unique case ({comp, term})
      4'b00_00: ts = '{qsel: QS_X, rsel: RS_X, neg: 1'b1};
      4'b00_01: ts = '{qsel: QS_Y, rsel: RS_Y, neg: 1'b1};
      4'b00_10: ts = '{qsel: QS_Z, rsel: RS_Z, neg: 1'b1};
      4'b01_00: ts = '{qsel: QS_W, rsel: RS_X, neg: 1'b0};
      4'b01_01: ts = '{qsel: QS_Y, rsel: RS_Z, neg: 1'b0};
      4'b01_10: ts = '{qsel: QS_Z, rsel: RS_Y, neg: 1'b1};
      4'b10_00: ts = '{qsel: QS_W, rsel: RS_Y, neg: 1'b0};
      4'b10_01: ts = '{qsel: QS_X, rsel: RS_Z, neg: 1'b1};
      4'b10_10: ts = '{qsel: QS_Z, rsel: RS_X, neg: 1'b0};
      4'b11_00: ts = '{qsel: QS_W, rsel: RS_Z, neg: 1'b0};
      4'b11_01: ts = '{qsel: QS_X, rsel: RS_Y, neg: 1'b0};
      4'b11_10: ts = '{qsel: QS_Y, rsel: RS_X, neg: 1'b1};
      default:  ts = '{qsel: QS_W, rsel: RS_X, neg: 1'b0};
    endcase
    return ts;
  endfunction

endpackage

// ===== rtl/core/qgi_mul.sv =====
module qgi_mul (
  input  logic                                clk,
  input  logic signed [qgi_pkg::MUL_W-1:0]    a,
  input  logic signed [qgi_pkg::MUL_W-1:0]    b,
  output logic signed [qgi_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= qgi_pkg::PROD_W'(a) * qgi_pkg::PROD_W'(b);
  end

endmodule

// ===== rtl/core/qgi_rootdiv.sv =====
module qgi_rootdiv #(
  parameter int FRAC_BITS = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  qgi_pkg::rd_req_t req,
  input  logic [63:0]      radicand,
  input  logic [30:0]      dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [63:0]      result
);

  logic        busy;
  logic        is_div;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] bitm;

  logic [63:0] sub_b;
  logic [64:0] diff;
  logic        ge;
  logic [63:0] rem_sel;
  logic [63:0] rem_next;
  logic [63:0] acc_next;

  // one compare-subtract shared by root and divide steps
  always_comb begin
    sub_b    = is_div ? {32'b0, divisor} : (acc | bitm);
    diff     = {1'b0, rem} - {1'b0, sub_b};
    ge       = ~diff[64];
    rem_sel  = ge ? diff[63:0] : rem;
    rem_next = is_div ? {rem_sel[62:0], 1'b0} : rem_sel;
    if (is_div) begin
      acc_next = {acc[62:0], ge};
    end else begin
      acc_next = ge ? ((acc >> 1) | bitm) : (acc >> 1);
    end
  end

  assign done   = busy && (cnt == 6'd1);
  assign result = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.is_div ? 6'(FRAC_BITS + 1) : 6'(qgi_pkg::ROOT_STEPS);
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc    <= '0;
      rem    <= req.is_div ? {33'b0, dividend} : radicand;
      bitm   <= 64'd1 << 62;
    end else if (busy) begin
      acc    <= acc_next;
      rem    <= rem_next;
      bitm   <= bitm >> 2;
    end
  end

endmodule

// ===== rtl/core/quaternion_gyro_integrator_unit.sv =====
// Gyro quaternion integrator.
// Input channel (in_valid/in_ready) takes one gyro sample rate_x/y/z, rad/s
// times 2^16. The block advances its attitude quaternion by one first-order
// step scaled by step_time/2, normalizes it and presents quat_w/x/y/z
// (FRAC_BITS fraction bits) and fell_back on the output channel
// (out_valid/out_ready). fell_back marks a zero-length sum replaced by identity.
// cfg_we/cfg_wdata write step_time (seconds times 2^20) with no wait.
// The cross products run on one registered multiplier; a rescaling then shifts
// the magnitudes one bit at a time, and the shared root/divide unit does a
// 32-step square root and four restoring divides. A zero-length sum skips to
// the output.
// in_ready is high only while no sample is in work.
// The result sits in an output register; if the receiver stalls, the next
// sample is still taken and computed, then waits until the register is free.
// Reset (rst, synchronous) sets the attitude to identity, step_time to 5243
// and empties the output register.
module quaternion_gyro_integrator_unit #(
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] rate_x,
  input  logic signed [23:0] rate_y,
  input  logic signed [23:0] rate_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               fell_back,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [30:0]        M_ONE = 31'd1 << FRAC_BITS;

  qgi_pkg::state_t state, state_next;

  logic [1:0]                           comp;
  logic [1:0]                           term;
  logic signed [23:0]                   rate_r [0:2];
  logic signed [31:0]                   q      [0:3];
  logic [qgi_pkg::NQ_W-1:0]             mag    [0:3];
  logic [3:0]                           neg;
  logic signed [qgi_pkg::ACC_W-1:0]     s;
  logic signed [39:0]                   hp;
  logic [63:0]                          sum;
  logic [63:0]                          sq_total;
  logic [31:0]                          nroot;
  logic                                 fell;
  logic [15:0]                          step;

  qgi_pkg::term_sel_t                   ts;
  logic signed [qgi_pkg::MUL_W-1:0]     mul_a;
  logic signed [qgi_pkg::MUL_W-1:0]     mul_b;
  logic signed [qgi_pkg::PROD_W-1:0]    prod;
  logic signed [41:0]                   t;
  logic signed [21:0]                   t_hi;
  logic signed [63:0]                   total;
  logic signed [qgi_pkg::NQ_W-1:0]      nq;
  logic [qgi_pkg::NQ_W-1:0]             nq_mag;
  logic                                 any_ge31;
  logic                                 any_ge30;
  logic                                 all_zero;
  logic [30:0]                          quo;
  logic [30:0]                          quo_lim;
  logic [1:0]                           comp_inc;

  qgi_pkg::rd_req_t                     rd_req;
  logic [30:0]                          rd_dividend;
  logic                                 rd_done;
  logic [63:0]                          rd_result;

  qgi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  qgi_rootdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rootdiv (
    .clk      (clk),
    .rst      (rst),
    .req      (rd_req),
    .radicand (sq_total),
    .dividend (rd_dividend),
    .divisor  (nroot),
    .done     (rd_done),
    .result   (rd_result)
  );

  assign in_ready = (state == qgi_pkg::ST_IDLE);
  assign comp_inc = comp + 2'd1;

  always_comb begin
    ts       = qgi_pkg::term_sel(comp, term);
    t        = s[qgi_pkg::ACC_W-1:16];
    t_hi     = t[41:20];
    total    = (64'(hp) <<< 20) + $signed(prod[63:0]);
    nq       = qgi_pkg::NQ_W'(q[comp]) + qgi_pkg::NQ_W'($signed(total[63:21]));
    nq_mag   = nq[qgi_pkg::NQ_W-1] ? 44'(-nq) : 44'(nq);
    any_ge31 = |{mag[0][43:31], mag[1][43:31], mag[2][43:31], mag[3][43:31]};
    any_ge30 = |{mag[0][43:30], mag[1][43:30], mag[2][43:30], mag[3][43:30]};
    all_zero = ~|{mag[0], mag[1], mag[2], mag[3]};
    quo      = rd_result[30:0];
    quo_lim  = (quo > M_ONE) ? M_ONE : quo;
    sq_total = sum + prod[63:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qgi_pkg::ST_IDLE:     if (in_valid) state_next = qgi_pkg::ST_TERM_MUL;
      qgi_pkg::ST_TERM_MUL: state_next = qgi_pkg::ST_TERM_ACC;
      qgi_pkg::ST_TERM_ACC: begin
        state_next = (term == 2'd2) ? qgi_pkg::ST_HI_MUL : qgi_pkg::ST_TERM_MUL;
      end
      qgi_pkg::ST_HI_MUL:   state_next = qgi_pkg::ST_HI_ACC;
      qgi_pkg::ST_HI_ACC:   state_next = qgi_pkg::ST_LO_MUL;
      qgi_pkg::ST_LO_MUL:   state_next = qgi_pkg::ST_LO_ACC;
      qgi_pkg::ST_LO_ACC: begin
        state_next = (comp == 2'd3) ? qgi_pkg::ST_CHECK : qgi_pkg::ST_TERM_MUL;
      end
      qgi_pkg::ST_CHECK: begin
        state_next = all_zero ? qgi_pkg::ST_OUT : qgi_pkg::ST_SCALE;
      end
      qgi_pkg::ST_SCALE: begin
        if (!any_ge31 && any_ge30) state_next = qgi_pkg::ST_SQ_MUL;
      end
      qgi_pkg::ST_SQ_MUL:   state_next = qgi_pkg::ST_SQ_ACC;
      qgi_pkg::ST_SQ_ACC: begin
        state_next = (comp == 2'd3) ? qgi_pkg::ST_ROOT : qgi_pkg::ST_SQ_MUL;
      end
      qgi_pkg::ST_ROOT:     if (rd_done) state_next = qgi_pkg::ST_DIV;
      qgi_pkg::ST_DIV:      if (rd_done && comp == 2'd3) state_next = qgi_pkg::ST_OUT;
      qgi_pkg::ST_OUT:      if (!out_valid || out_ready) state_next = qgi_pkg::ST_IDLE;
      default:              state_next = qgi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    rd_req      = '{start: 1'b0, is_div: 1'b0};
    rd_dividend = (state == qgi_pkg::ST_ROOT) ? mag[0][30:0] : mag[comp_inc][30:0];
    unique case (state)
      qgi_pkg::ST_TERM_MUL: begin
        mul_a = 33'(q[ts.qsel]);
        mul_b = 33'(rate_r[ts.rsel]);
      end
      qgi_pkg::ST_HI_MUL: begin
        mul_a = 33'(t_hi);
        mul_b = {17'b0, step};
      end
      qgi_pkg::ST_LO_MUL: begin
        mul_a = {13'b0, t[19:0]};
        mul_b = {17'b0, step};
      end
      qgi_pkg::ST_SQ_MUL: begin
        mul_a = {2'b0, mag[comp][30:0]};
        mul_b = {2'b0, mag[comp][30:0]};
      end
      qgi_pkg::ST_SQ_ACC: begin
        rd_req = '{start: (comp == 2'd3), is_div: 1'b0};
      end
      qgi_pkg::ST_ROOT: begin
        rd_req = '{start: rd_done, is_div: 1'b1};
      end
      qgi_pkg::ST_DIV: begin
        rd_req = '{start: rd_done && (comp != 2'd3), is_div: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qgi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 16'd5243;
    end else if (cfg_we) begin
      step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q[0] <= Q_ONE;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
      comp <= '0;
      term <= '0;
    end else begin
      unique case (state)
        qgi_pkg::ST_IDLE: begin
          if (in_valid) begin
            rate_r[0] <= rate_x;
            rate_r[1] <= rate_y;
            rate_r[2] <= rate_z;
            comp      <= '0;
            term      <= '0;
            s         <= '0;
          end
        end
        qgi_pkg::ST_TERM_ACC: begin
          s    <= s + (ts.neg ? -prod[qgi_pkg::ACC_W-1:0] : prod[qgi_pkg::ACC_W-1:0]);
          term <= (term == 2'd2) ? 2'd0 : term + 2'd1;
        end
        qgi_pkg::ST_HI_ACC: begin
          hp <= prod[39:0];
        end
        qgi_pkg::ST_LO_ACC: begin
          mag[comp] <= nq_mag;
          neg[comp] <= nq[qgi_pkg::NQ_W-1];
          s         <= '0;
          comp      <= comp_inc;
        end
        qgi_pkg::ST_CHECK: begin
          fell <= all_zero;
          sum  <= '0;
          if (all_zero) begin
            q[0] <= Q_ONE;
            q[1] <= '0;
            q[2] <= '0;
            q[3] <= '0;
          end
        end
        qgi_pkg::ST_SCALE: begin
          for (int i = 0; i < 4; i++) begin
            if (any_ge31) begin
              mag[i] <= mag[i] >> 1;
            end else if (!any_ge30) begin
              mag[i] <= mag[i] << 1;
            end
          end
        end
        qgi_pkg::ST_SQ_ACC: begin
          sum  <= sq_total;
          comp <= comp_inc;
        end
        qgi_pkg::ST_ROOT: begin
          if (rd_done) begin
            nroot <= rd_result[31:0];
          end
        end
        qgi_pkg::ST_DIV: begin
          if (rd_done) begin
            q[comp] <= neg[comp] ? -$signed({1'b0, quo_lim}) : $signed({1'b0, quo_lim});
            comp    <= comp_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == qgi_pkg::ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      quat_w    <= q[0];
      quat_x    <= q[1];
      quat_y    <= q[2];
      quat_z    <= q[3];
      fell_back <= fell;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_fell_identity: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fell_back) |-> (quat_w == Q_ONE && quat_x == 0 && quat_y == 0 && quat_z == 0))
    else $error("fallback result is not identity");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quat_w <= Q_ONE && quat_w >= -Q_ONE && quat_x <= Q_ONE && quat_x >= -Q_ONE))
    else $error("output component out of range");

  a_unit_done_phase: assert property (@(posedge clk) disable iff (rst)
    rd_done |-> (state == qgi_pkg::ST_ROOT || state == qgi_pkg::ST_DIV))
    else $error("root/divide unit finished outside its phase");

  a_root_normalized: assert property (@(posedge clk) disable iff (rst)
    (state == qgi_pkg::ST_ROOT && rd_done) |-> rd_result[31:30] != 2'b00)
    else $error("root of scaled sum below 2^30");
`endif

endmodule

// ===== tb/quaternion_gyro_integrator_unit_tb.sv =====
`timescale 1ns / 1ps

module quaternion_gyro_integrator_unit_tb;

  localparam int FRAC_BITS = 30;
  localparam int LATENCY = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               fb;
  } attitude_t;

  class attitude_scoreboard;
    longint    quat[4];
    longint    step_time;
    attitude_t pending[$];
    int        errors;
    int        matched;
    int        fallbacks;

    function new();
      quat[0] = longint'(1) << FRAC_BITS;
      quat[1] = 0;
      quat[2] = 0;
      quat[3] = 0;
      step_time = 5243;
      errors = 0;
      matched = 0;
      fallbacks = 0;
    endfunction

    function longint half_step(longint s);
      longint t;
      t = s >>> 16;
      return (t * step_time) >>> 21;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_sample(logic signed [23:0] rx, logic signed [23:0] ry,
                              logic signed [23:0] rz);
      longint          sx, sy, sz;
      longint          nq[4];
      longint unsigned mag[4];
      bit              neg[4];
      longint unsigned maxm, sum, n, m, one;
      attitude_t       r;
      sx = longint'(rx);
      sy = longint'(ry);
      sz = longint'(rz);
      one = 64'd1 << FRAC_BITS;
      nq[0] = quat[0] + half_step(-quat[1] * sx - quat[2] * sy - quat[3] * sz);
      nq[1] = quat[1] + half_step(quat[0] * sx + quat[2] * sz - quat[3] * sy);
      nq[2] = quat[2] + half_step(quat[0] * sy - quat[1] * sz + quat[3] * sx);
      nq[3] = quat[3] + half_step(quat[0] * sz + quat[1] * sy - quat[2] * sx);
      maxm = 0;
      for (int i = 0; i < 4; i++) begin
        neg[i] = nq[i] < 0;
        mag[i] = neg[i] ? longint'(-nq[i]) : longint'(nq[i]);
        if (mag[i] > maxm) maxm = mag[i];
      end
      if (maxm == 0) begin
        quat[0] = longint'(one);
        quat[1] = 0;
        quat[2] = 0;
        quat[3] = 0;
        r.fb = 1'b1;
      end else begin
        while (maxm >= (64'd1 << 31)) begin
          for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
          maxm = maxm >> 1;
        end
        while (maxm < (64'd1 << 30)) begin
          for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
          maxm = maxm << 1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
        n = int_sqrt(sum);
        for (int i = 0; i < 4; i++) begin
          m = (mag[i] << FRAC_BITS) / n;
          if (m > one) m = one;
          quat[i] = neg[i] ? -longint'(m) : longint'(m);
        end
        r.fb = 1'b0;
      end
      r.w = quat[0][31:0];
      r.x = quat[1][31:0];
      r.y = quat[2][31:0];
      r.z = quat[3][31:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] w, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z, logic fb);
      attitude_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer w=%0d x=%0d y=%0d z=%0d fell_back=%0b",
                 $time, w, x, y, z, fb);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (fb) fallbacks++;
      if (w !== e.w || x !== e.x || y !== e.y || z !== e.z || fb !== e.fb) begin
        $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d fb=%0b", $time,
                 e.w, e.x, e.y, e.z, e.fb);
        $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d fb=%0b", $time,
                 w, x, y, z, fb);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] rate_x, rate_y, rate_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic               fell_back;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  attitude_scoreboard sb;
  bit  steady;
  bit  hold_req;
  int  idle_cycles;
  int  sent;

  quaternion_gyro_integrator_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .fell_back(fell_back),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_sample(logic signed [23:0] rx, logic signed [23:0] ry,
                             logic signed [23:0] rz);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    rate_x = rx;
    rate_y = ry;
    rate_z = rz;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(rx, ry, rz);
    sent++;
    if (!steady && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 300);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_step(logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = val;
    sb.step_time = longint'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random(int count, bit realistic);
    logic signed [23:0] rx, ry, rz;
    for (int i = 0; i < count; i++) begin
      if (realistic && $urandom_range(9) < 8) begin
        rx = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
        ry = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
        rz = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
      end else begin
        rx = 24'($urandom);
        ry = 24'($urandom);
        rz = 24'($urandom);
      end
      send_sample(rx, ry, rz);
    end
  endtask

  // receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(quat_w, quat_x, quat_y, quat_z, fell_back);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    steady = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    rate_x = '0;
    rate_y = '0;
    rate_z = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset step time
    send_sample(24'sd0, 24'sd0, 24'sd0);
    send_sample(24'sh7FFFFF, 24'sd0, 24'sd0);
    send_sample(24'sd0, 24'sh7FFFFF, 24'sd0);
    send_sample(24'sd0, 24'sd0, 24'sh7FFFFF);
    send_sample(-24'sh800000, 24'sd0, 24'sd0);
    send_sample(24'sd0, -24'sh800000, 24'sd0);
    send_sample(24'sd0, 24'sd0, -24'sh800000);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_sample(-24'sh800000, -24'sh800000, -24'sh800000);
    send_sample(24'sh7FFFFF, -24'sh800000, 24'sd1);
    send_sample(-24'sd1, -24'sd1, -24'sd1);
    send_sample(24'sd65536, 24'sd0, 24'sd0);
    drain();

    // zero step only renormalizes
    write_step(16'd0);
    send_sample(24'sh7FFFFF, -24'sh800000, 24'sh123456);
    send_sample(-24'sd1, 24'sd1, 24'sd0);
    drain();

    write_step(16'hFFFF);
    send_sample(24'sh7FFFFF, 24'sd0, 24'sd0);
    send_sample(-24'sh800000, -24'sh800000, 24'sh7FFFFF);
    send_sample(24'sd0, 24'sd0, 24'sd0);
    send_sample(24'sd1, -24'sd1, 24'sd1);
    drain();

    write_step(16'd5243);
    hold_req = 1'b1;
    send_random(450, 1'b1);
    drain();

    write_step(16'hFFFF);
    send_random(300, 1'b0);
    drain();

    write_step(16'd1);
    steady = 1'b1;
    send_random(250, 1'b1);
    steady = 1'b0;
    drain();

    write_step(16'd0);
    send_random(100, 1'b0);
    drain();

    write_step(16'($urandom));
    send_random(350, 1'b1);
    drain();

    write_step(16'($urandom));
    send_random(280, 1'b0);
    drain();

    $display("Sent %0d gyro samples over six step_time settings incl. 0 and 65535;", sent);
    $display("%0d attitudes matched, %0d errors, %0d identity fallbacks seen.",
             sb.matched, sb.errors, sb.fallbacks);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qgi_pkg.sv
rtl/core/qgi_mul.sv
rtl/core/qgi_rootdiv.sv
rtl/core/quaternion_gyro_integrator_unit.sv
tb/quaternion_gyro_integrator_unit_tb.sv
